@@ rtl/core/pva_pkg.sv @@
// Package for the priority voice allocator.
// Holds sizes, command codes, voice modes and the records passed between cells.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pva_pkg;
    localparam int VOICES = 32;
    localparam int SLOT_W = 5;
    localparam int CNT_W = 6;
    localparam int ID_W = 31;
    localparam int PRIO_W = 9;
    localparam int REQ_W = 8;
    localparam int KIND_W = 3;
    localparam int IN_W = 48;
    localparam int OUT_W = 40;

    localparam logic [KIND_W-1:0] K_PLAY = 3'd0;
    localparam logic [KIND_W-1:0] K_STOP = 3'd1;
    localparam logic [KIND_W-1:0] K_PAUSE = 3'd2;
    localparam logic [KIND_W-1:0] K_RESUME = 3'd3;
    localparam logic [KIND_W-1:0] K_AUTO_PAUSE = 3'd4;
    localparam logic [KIND_W-1:0] K_AUTO_RESUME = 3'd5;
    localparam logic [KIND_W-1:0] K_SET_PRIO = 3'd6;
    localparam logic [KIND_W-1:0] K_FINISHED = 3'd7;

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_PLAYING = 2'd1;
    localparam logic [1:0] M_PAUSED = 2'd2;

    localparam logic signed [PRIO_W-1:0] IDLE_PRIO = -9'sd1;
    localparam logic [CNT_W-1:0] MAX_COUNT = 6'd32;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic signed [PRIO_W-1:0] prio;
    } pos_rec_t;

    typedef struct packed {
        logic init;
        logic play;
        logic move;
        logic setp;
        logic [CNT_W-1:0] count;
        pos_rec_t head_rec;
        pos_rec_t move_rec;
        logic [SLOT_W-1:0] setp_slot;
        logic signed [PRIO_W-1:0] req_prio;
    } pos_ctl_t;

    typedef struct packed {
        logic init;
        logic play;
        logic idle;
        logic pause;
        logic resume;
        logic auto_pause;
        logic auto_resume;
        logic [CNT_W-1:0] count;
        logic [ID_W-1:0] new_id;
    } voice_ctl_t;
endpackage
`default_nettype wire

@@ rtl/core/pva_pos_cell.sv @@
// One position of the ordered voice list: slot number and its priority.
// Shifts to and from its neighbors for steal-and-insert and move-to-front; uses pva_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pva_pos_cell (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [pva_pkg::SLOT_W-1:0] idx,
    input  wire pva_pkg::pos_ctl_t          ctl,
    input  wire pva_pkg::pos_rec_t          next_rec,
    input  wire pva_pkg::pos_rec_t          prev_rec,
    input  wire logic                       chain_in,
    output logic                            chain_out,
    output pva_pkg::pos_rec_t               rec
);
    import pva_pkg::*;

    pos_rec_t rec_reg;
    pos_rec_t rec_next;
    logic in_use;
    logic last;
    logic hit;

    assign in_use = ({1'b0, idx} < ctl.count);
    assign last = ({1'b0, idx} == ctl.count - CNT_W'(1));

    always_comb
    begin
        hit = 1'b0;
        if (ctl.play)
        begin
            hit = in_use && !last && (ctl.req_prio < next_rec.prio);
        end
        else
        begin
            hit = in_use && (rec_reg.slot == ctl.move_rec.slot);
        end
    end

    assign chain_out = chain_in | hit;

    always_comb
    begin
        rec_next = rec_reg;
        if (ctl.init)
        begin
            rec_next.slot = idx;
            rec_next.prio = IDLE_PRIO;
        end
        else if (ctl.play && in_use && !chain_in)
        begin
            if (!hit && !last)
            begin
                rec_next = next_rec;
            end
            else
            begin
                rec_next = ctl.head_rec;
            end
        end
        else if (ctl.move && in_use && !chain_in)
        begin
            if (idx == '0)
            begin
                rec_next = ctl.move_rec;
            end
            else
            begin
                rec_next = prev_rec;
            end
        end
        else if (ctl.setp && rec_reg.slot == ctl.setp_slot)
        begin
            rec_next.prio = ctl.req_prio;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg.slot <= idx;
            rec_reg.prio <= IDLE_PRIO;
        end
        else
        begin
            rec_reg <= rec_next;
        end
    end

    assign rec = rec_reg;
endmodule
`default_nettype wire

@@ rtl/core/pva_voice.sv @@
// State of one voice slot: identifier, playback mode and auto-pause flag.
// Driven by the allocator top level; uses pva_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pva_voice (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [pva_pkg::SLOT_W-1:0] idx,
    input  wire pva_pkg::voice_ctl_t        ctl,
    input  wire logic                       sel,
    output logic [pva_pkg::ID_W-1:0]        id,
    output logic [1:0]                      mode
);
    import pva_pkg::*;

    logic [ID_W-1:0] id_reg;
    logic [ID_W-1:0] id_next;
    logic [1:0] mode_reg;
    logic [1:0] mode_next;
    logic auto_reg;
    logic auto_next;
    logic in_use;

    assign in_use = ({1'b0, idx} < ctl.count);

    always_comb
    begin
        id_next = id_reg;
        mode_next = mode_reg;
        auto_next = auto_reg;
        if (ctl.init)
        begin
            id_next = '0;
            mode_next = M_IDLE;
            auto_next = 1'b0;
        end
        else if (sel && ctl.play)
        begin
            id_next = ctl.new_id;
            mode_next = M_PLAYING;
        end
        else if (sel && ctl.idle)
        begin
            mode_next = M_IDLE;
        end
        else if (sel && ctl.pause && mode_reg == M_PLAYING)
        begin
            mode_next = M_PAUSED;
        end
        else if (sel && ctl.resume && mode_reg == M_PAUSED)
        begin
            mode_next = M_PLAYING;
            auto_next = 1'b0;
        end
        else if (ctl.auto_pause && in_use && mode_reg == M_PLAYING)
        begin
            mode_next = M_PAUSED;
            auto_next = 1'b1;
        end
        else if (ctl.auto_resume && in_use && auto_reg && mode_reg == M_PAUSED)
        begin
            mode_next = M_PLAYING;
            auto_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg <= '0;
            mode_reg <= M_IDLE;
            auto_reg <= 1'b0;
        end
        else
        begin
            id_reg <= id_next;
            mode_reg <= mode_next;
            auto_reg <= auto_next;
        end
    end

    assign id = id_reg;
    assign mode = mode_reg;
endmodule
`default_nettype wire

@@ rtl/core/priority_voice_allocator.sv @@
// Priority voice allocator top level: command decode, identifier counter, result register.
// Instantiates the list position chain (pva_pos_cell) and voice slots (pva_voice); uses pva_pkg.
//
// A command word enters on s_axis: tuser carries the command kind, tdata the operands.
// One result word per command leaves on m_axis. The cfg channel writes the number of
// active voices (clamped to 1..32); a write restarts all voice state and the identifier
// counter as after reset, and is taken in any cycle.
// A command is registered in the cycle it is accepted and executed in the next cycle
// in which the result register is free or being emptied; the result word is registered
// at execution. s_axis_tready is low from acceptance until execution, so a new command
// is not taken before the last one has executed. The ordered list is a row of position
// cells that shift into each other in that execution cycle.
// A stalled m_axis holds its word and blocks execution of the next command.
// Reset gives 32 active voices, all idle, listed in slot order.
`timescale 1ns / 1ps
`default_nettype none
module priority_voice_allocator (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // sample_ready, priority_req[7:0], channel_id[30:0], voice_slot[4:0], zero fill
    input  wire logic [pva_pkg::IN_W-1:0]    s_axis_tdata,
    // kind[2:0]
    input  wire logic [pva_pkg::KIND_W-1:0]  s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // granted_id[30:0], slot[4:0], matched, was_stolen, zero fill
    output logic [pva_pkg::OUT_W-1:0]        m_axis_tdata,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [pva_pkg::CNT_W-1:0]   cfg_data
);
    import pva_pkg::*;

    logic busy_reg;
    logic [KIND_W-1:0] kind_reg;
    logic ready_reg;
    logic [REQ_W-1:0] req_reg;
    logic [ID_W-1:0] cid_reg;
    logic [SLOT_W-1:0] vslot_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [ID_W-1:0] idc_reg;
    logic [ID_W-1:0] idc_next;
    logic out_valid_reg;
    logic [OUT_W-1:0] out_reg;

    pos_rec_t recs [VOICES];
    logic chains [VOICES];
    logic [ID_W-1:0] ids [VOICES];
    logic [1:0] modes [VOICES];
    logic [VOICES-1:0] sel;

    pos_ctl_t pctl;
    voice_ctl_t vctl;
    logic go;
    logic init;
    logic s_acc;
    logic signed [PRIO_W-1:0] req_s;
    logic play_ok;
    logic found;
    logic [SLOT_W-1:0] fslot;
    logic fin_ok;
    logic idle_go;
    logic [SLOT_W-1:0] idle_slot;
    logic [PRIO_W-1:0] move_prio;
    logic [SLOT_W-1:0] tgt_slot;
    logic [ID_W-1:0] inc_id;
    logic [ID_W-1:0] res_gid;
    logic [SLOT_W-1:0] res_slot;
    logic res_match;
    logic res_stolen;

    assign cfg_ready = 1'b1;
    assign init = cfg_valid;
    assign s_axis_tready = !busy_reg;
    assign s_acc = s_axis_tvalid && !busy_reg;
    assign go = busy_reg && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        if (cfg_data == '0)
        begin
            count_next = CNT_W'(1);
        end
        else if (cfg_data > MAX_COUNT)
        begin
            count_next = MAX_COUNT;
        end
        else
        begin
            count_next = cfg_data;
        end
    end

    assign req_s = $signed({1'b0, req_reg});
    assign play_ok = (kind_reg == K_PLAY) && ready_reg && (req_s >= recs[0].prio);

    always_comb
    begin
        found = 1'b0;
        fslot = '0;
        for (int i = VOICES - 1; i >= 0; i--)
        begin
            if (CNT_W'(i) < count_reg && ids[i] == cid_reg)
            begin
                found = 1'b1;
                fslot = SLOT_W'(i);
            end
        end
    end

    assign fin_ok = ({1'b0, vslot_reg} < count_reg);
    assign idle_go = ((kind_reg == K_STOP) && found) || ((kind_reg == K_FINISHED) && fin_ok);
    assign idle_slot = (kind_reg == K_FINISHED) ? vslot_reg : fslot;
    assign tgt_slot = (kind_reg == K_PLAY) ? recs[0].slot : idle_slot;

    always_comb
    begin
        move_prio = '0;
        for (int j = 0; j < VOICES; j++)
        begin
            if (CNT_W'(j) < count_reg && recs[j].slot == idle_slot)
            begin
                move_prio = move_prio | recs[j].prio;
            end
        end
        if (modes[idle_slot] != M_IDLE)
        begin
            move_prio = IDLE_PRIO;
        end
    end

    assign inc_id = (idc_reg + ID_W'(1) == '0) ? ID_W'(1) : idc_reg + ID_W'(1);
    assign idc_next = (go && play_ok) ? inc_id : idc_reg;

    always_comb
    begin
        pctl.init = init;
        pctl.play = go && play_ok;
        pctl.move = go && idle_go;
        pctl.setp = go && (kind_reg == K_SET_PRIO) && found;
        pctl.count = count_reg;
        pctl.head_rec.slot = recs[0].slot;
        pctl.head_rec.prio = req_s;
        pctl.move_rec.slot = idle_slot;
        pctl.move_rec.prio = $signed(move_prio);
        pctl.setp_slot = fslot;
        pctl.req_prio = req_s;

        vctl.init = init;
        vctl.play = go && play_ok;
        vctl.idle = go && idle_go;
        vctl.pause = go && (kind_reg == K_PAUSE) && found;
        vctl.resume = go && (kind_reg == K_RESUME) && found;
        vctl.auto_pause = go && (kind_reg == K_AUTO_PAUSE);
        vctl.auto_resume = go && (kind_reg == K_AUTO_RESUME);
        vctl.count = count_reg;
        vctl.new_id = inc_id;
    end

    genvar g;
    generate
        for (g = 0; g < VOICES; g++)
        begin : g_cells
            pos_rec_t nrec;
            pos_rec_t prec;
            logic cin;

            assign nrec = (g == VOICES - 1) ? recs[g] : recs[(g + 1) % VOICES];
            assign prec = (g == 0) ? recs[g] : recs[(g + VOICES - 1) % VOICES];
            assign cin = (g == 0) ? 1'b0 : chains[(g + VOICES - 1) % VOICES];
            assign sel[g] = (tgt_slot == SLOT_W'(g));

            pva_pos_cell u_pos (
                .clk       (clk),
                .rst_n     (rst_n),
                .idx       (SLOT_W'(g)),
                .ctl       (pctl),
                .next_rec  (nrec),
                .prev_rec  (prec),
                .chain_in  (cin),
                .chain_out (chains[g]),
                .rec       (recs[g])
            );

            pva_voice u_voice (
                .clk   (clk),
                .rst_n (rst_n),
                .idx   (SLOT_W'(g)),
                .ctl   (vctl),
                .sel   (sel[g]),
                .id    (ids[g]),
                .mode  (modes[g])
            );
        end
    endgenerate

    always_comb
    begin
        res_gid = '0;
        res_slot = '0;
        res_match = 1'b0;
        res_stolen = 1'b0;
        if (play_ok)
        begin
            res_gid = inc_id;
            res_slot = recs[0].slot;
            res_match = 1'b1;
            res_stolen = (modes[recs[0].slot] != M_IDLE);
        end
        else if ((kind_reg == K_STOP || kind_reg == K_PAUSE || kind_reg == K_RESUME
                  || kind_reg == K_SET_PRIO) && found)
        begin
            res_slot = fslot;
            res_match = 1'b1;
        end
        else if (kind_reg == K_FINISHED && fin_ok)
        begin
            res_slot = vslot_reg;
            res_match = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg <= MAX_COUNT;
            idc_reg <= '0;
        end
        else
        begin
            if (s_acc)
            begin
                busy_reg <= 1'b1;
            end
            else if (go)
            begin
                busy_reg <= 1'b0;
            end
            if (go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (init)
            begin
                count_reg <= count_next;
                idc_reg <= '0;
            end
            else
            begin
                idc_reg <= idc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            kind_reg <= s_axis_tuser;
            ready_reg <= s_axis_tdata[0];
            req_reg <= s_axis_tdata[8:1];
            cid_reg <= s_axis_tdata[39:9];
            vslot_reg <= s_axis_tdata[44:40];
        end
        if (go)
        begin
            out_reg <= {2'b00, res_stolen, res_match, res_slot, res_gid};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_reg;
endmodule
`default_nettype wire

@@ tb/sv/tb_priority_voice_allocator.sv @@
// Self-checking testbench for priority_voice_allocator: a behavioral voice list
// predicts every result word, which is compared field by field as it leaves m_axis.
// Depends on pva_pkg and the priority_voice_allocator RTL.
`timescale 1ns / 1ps
module tb_priority_voice_allocator;
    import pva_pkg::*;

    typedef struct packed {
        logic              stolen;
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   gid;
    } alloc_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic [KIND_W-1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CNT_W-1:0] cfg_data = '0;

    int n_active;
    logic [SLOT_W-1:0] order_q [VOICES];
    logic signed [PRIO_W-1:0] prio_q [VOICES];
    logic [ID_W-1:0] id_q [VOICES];
    logic [1:0] mode_q [VOICES];
    logic auto_q [VOICES];
    logic [ID_W-1:0] id_ctr;

    alloc_res_t pending_res [$];
    int errors = 0;
    int cycles = 0;
    logic [ID_W-1:0] last_gid;

    priority_voice_allocator u_top (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 25);
    endfunction

    task automatic voices_init(input int cnt);
        n_active = cnt < 1 ? 1 : (cnt > VOICES ? VOICES : cnt);
        for (int i = 0; i < VOICES; i++)
        begin
            order_q[i] = i[SLOT_W-1:0];
            prio_q[i] = IDLE_PRIO;
            id_q[i] = '0;
            mode_q[i] = M_IDLE;
            auto_q[i] = 1'b0;
        end
        id_ctr = '0;
    endtask

    task automatic move_to_front(input int s);
        int p;
        p = 0;
        while (p < n_active && order_q[p] != s) p++;
        if (p >= n_active) return;
        for (int k = p; k > 0; k--) order_q[k] = order_q[k-1];
        order_q[0] = s[SLOT_W-1:0];
    endtask

    task automatic silence_voice(input int s);
        if (mode_q[s] != M_IDLE)
        begin
            mode_q[s] = M_IDLE;
            prio_q[s] = IDLE_PRIO;
        end
        move_to_front(s);
    endtask

    function automatic int lookup_id(input logic [ID_W-1:0] cid);
        for (int i = 0; i < n_active; i++)
            if (id_q[i] == cid) return i;
        return -1;
    endfunction

    task automatic allocate_voice(input logic [KIND_W-1:0] kind, input logic rdy,
                                  input logic [7:0] preq, input logic [ID_W-1:0] cid,
                                  input logic [SLOT_W-1:0] vslot, output alloc_res_t r);
        logic signed [PRIO_W-1:0] p;
        int head, k, f;
        r = '0;
        p = {1'b0, preq};
        case (kind)
            K_PLAY:
            begin
                head = order_q[0];
                if (rdy && p >= prio_q[head])
                begin
                    for (k = 0; k + 1 < n_active; k++) order_q[k] = order_q[k+1];
                    for (k = 0; k + 1 < n_active; k++)
                        if (p < prio_q[order_q[k]]) break;
                    for (int i = n_active - 1; i > k; i--) order_q[i] = order_q[i-1];
                    order_q[k] = head[SLOT_W-1:0];
                    r.stolen = mode_q[head] != M_IDLE;
                    prio_q[head] = p;
                    id_ctr = id_ctr + 1'b1;
                    if (id_ctr == '0) id_ctr = ID_W'(1);
                    id_q[head] = id_ctr;
                    mode_q[head] = M_PLAYING;
                    r.gid = id_ctr;
                    r.slot = head[SLOT_W-1:0];
                    r.hit = 1'b1;
                end
            end
            K_STOP, K_PAUSE, K_RESUME, K_SET_PRIO:
            begin
                f = lookup_id(cid);
                if (f >= 0)
                begin
                    r.slot = f[SLOT_W-1:0];
                    r.hit = 1'b1;
                    if (kind == K_STOP) silence_voice(f);
                    else if (kind == K_PAUSE)
                    begin
                        if (mode_q[f] == M_PLAYING) mode_q[f] = M_PAUSED;
                    end
                    else if (kind == K_RESUME)
                    begin
                        if (mode_q[f] == M_PAUSED)
                        begin
                            mode_q[f] = M_PLAYING;
                            auto_q[f] = 1'b0;
                        end
                    end
                    else prio_q[f] = p;
                end
            end
            K_AUTO_PAUSE:
                for (int i = 0; i < n_active; i++)
                    if (mode_q[i] == M_PLAYING)
                    begin
                        mode_q[i] = M_PAUSED;
                        auto_q[i] = 1'b1;
                    end
            K_AUTO_RESUME:
                for (int i = 0; i < n_active; i++)
                    if (auto_q[i] && mode_q[i] == M_PAUSED)
                    begin
                        mode_q[i] = M_PLAYING;
                        auto_q[i] = 1'b0;
                    end
            default:
                if (vslot < n_active)
                begin
                    silence_voice(vslot);
                    r.slot = vslot;
                    r.hit = 1'b1;
                end
        endcase
    endtask

    task automatic send_cmd(input logic [KIND_W-1:0] kind, input logic rdy,
                            input logic [7:0] preq, input logic [ID_W-1:0] cid,
                            input logic [SLOT_W-1:0] vslot);
        alloc_res_t r;
        int g;
        g = gap_len();
        if (g > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {3'b0, vslot, cid, preq, rdy};
        do @(posedge clk); while (!s_axis_tready);
        allocate_voice(kind, rdy, preq, cid, vslot, r);
        if (r.gid != 0) last_gid = r.gid;
        pending_res = {pending_res, r};
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (pending_res.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (6) @(posedge clk);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        voices_init(v);
    endtask

    always @(posedge clk)
    begin
        alloc_res_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[$bits(alloc_res_t)-1:0];
            if (pending_res.size() == 0)
                report_mismatch("unexpected word", 64'(got), 64'(0));
            else
            begin
                want = pending_res.pop_front();
                if (got.gid != want.gid)
                    report_mismatch("granted_id", 64'(got.gid), 64'(want.gid));
                if (got.slot != want.slot)
                    report_mismatch("slot", 64'(got.slot), 64'(want.slot));
                if (got.hit != want.hit)
                    report_mismatch("matched", 64'(got.hit), 64'(want.hit));
                if (got.stolen != want.stolen)
                    report_mismatch("was_stolen", 64'(got.stolen), 64'(want.stolen));
            end
        end
    end

    logic calm = 1'b0;
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0) calm <= ~calm;
        if (calm) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 99) < 60) ||
                              ($urandom_range(0, 99) < 3 ? 1'b0 : m_axis_tready);
    end

    function automatic logic [ID_W-1:0] any_id();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return id_q[$urandom_range(0, n_active - 1)];
        if (r < 7) return last_gid;
        return ID_W'({$urandom, $urandom});
    endfunction

    task automatic test_directed();
        send_cmd(K_PLAY, 1'b0, 8'd255, '0, '0);
        send_cmd(K_PLAY, 1'b1, 8'd0, '0, '0);
        send_cmd(K_PLAY, 1'b1, 8'd255, '0, '0);
        send_cmd(K_PLAY, 1'b1, 8'd128, '0, '0);
        send_cmd(K_STOP, 1'b0, 8'd0, 31'd2, '0);
        send_cmd(K_STOP, 1'b0, 8'd0, 31'd0, '0);
        send_cmd(K_PAUSE, 1'b1, 8'd0, 31'd1, '0);
        send_cmd(K_RESUME, 1'b0, 8'd0, 31'd1, '0);
        send_cmd(K_AUTO_PAUSE, 1'b0, 8'd0, '0, '0);
        send_cmd(K_PAUSE, 1'b0, 8'd0, 31'd3, '0);
        send_cmd(K_AUTO_RESUME, 1'b0, 8'd0, '0, '0);
        send_cmd(K_SET_PRIO, 1'b0, 8'd7, 31'd1, '0);
        send_cmd(K_SET_PRIO, 1'b0, 8'd7, 31'h7FFFFFFF, 5'd31);
        send_cmd(K_FINISHED, 1'b0, 8'd0, '0, 5'd31);
        send_cmd(K_FINISHED, 1'b0, 8'd0, '0, 5'd0);
        send_cmd(K_PLAY, 1'b1, 8'd1, '0, '0);
        write_count(6'd1);
        send_cmd(K_PLAY, 1'b1, 8'd5, '0, '0);
        send_cmd(K_PLAY, 1'b1, 8'd4, '0, '0);
        send_cmd(K_PLAY, 1'b1, 8'd5, '0, '0);
        send_cmd(K_FINISHED, 1'b1, 8'hFF, 31'h7FFFFFFF, 5'd1);
        write_count(6'd0);
        send_cmd(K_FINISHED, 1'b0, 8'd0, '0, 5'd1);
        write_count(6'd63);
        send_cmd(K_FINISHED, 1'b0, 8'd0, '0, 5'd31);
    endtask

    task automatic test_random(input int n_items);
        int r;
        logic [KIND_W-1:0] kind;
        for (int i = 0; i < n_items; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40) kind = K_PLAY;
            else if (r < 52) kind = K_STOP;
            else if (r < 62) kind = K_PAUSE;
            else if (r < 72) kind = K_RESUME;
            else if (r < 76) kind = K_AUTO_PAUSE;
            else if (r < 80) kind = K_AUTO_RESUME;
            else if (r < 90) kind = K_SET_PRIO;
            else kind = K_FINISHED;
            send_cmd(kind, $urandom_range(0, 9) != 0, 8'($urandom), any_id(),
                     SLOT_W'($urandom));
        end
    endtask

    initial
    begin
        last_gid = '0;
        voices_init(VOICES);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        write_count(6'd32);
        test_random(500);
        write_count(6'd4);
        test_random(300);
        write_count(6'd17);
        test_random(300);
        write_count(6'd1);
        test_random(100);
        write_count(6'd32);
        test_random(250);
        drain();
        if (errors == 0 && pending_res.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
